FILE: hw/rtl/picr_pkg.sv
// Package for the pulse interval command receiver: field widths, reset values,
// command and request codes, and the types shared by the top level and the decoder.
// No dependencies.
`timescale 1ns / 1ps

package picr_pkg;

  localparam int TIME_W    = 32;
  localparam int TOUT_W    = 20;
  localparam int GAP_W     = 17;
  localparam int CODE_W    = 5;
  localparam int REQ_W     = 4;
  localparam int NUM_W     = 27;
  localparam int PSTATE_W  = 2;
  localparam int SHIFT_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [TOUT_W-1:0]  FRAME_TIMEOUT_RST = TOUT_W'(25320);
  localparam logic [GAP_W-1:0]   LONG_GAP_RST      = GAP_W'(1500);
  localparam logic [SHIFT_W-1:0] RESTART_PATTERN   = 16'h5555;
  localparam logic [SHIFT_W-1:0] FRAME_MASK        = 16'h0383;
  localparam logic [SHIFT_W-1:0] FRAME_MATCH       = 16'h0080;
  localparam logic [NUM_W-1:0]   NUM_MAX           = NUM_W'(99999999);
  localparam logic [NUM_W-1:0]   SPEED_SLOW        = NUM_W'(5);
  localparam logic [NUM_W-1:0]   SPEED_FAST        = NUM_W'(3);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP      = 1'b1;

  typedef enum logic [PSTATE_W-1:0] {
    PS_OTHER    = 2'd0,
    PS_EJECTED  = 2'd1,
    PS_PARKED   = 2'd2,
    PS_SCANNING = 2'd3
  } pstate_t;

  typedef enum logic [CODE_W-1:0] {
    CMD_DIGIT0   = 5'h01,
    CMD_SLOWREV  = 5'h02,
    CMD_DIGIT8   = 5'h03,
    CMD_STEPFWD  = 5'h04,
    CMD_DIGIT4   = 5'h05,
    CMD_SCANFWD  = 5'h08,
    CMD_DIGIT2   = 5'h09,
    CMD_PAUSE    = 5'h0a,
    CMD_FASTREV  = 5'h0c,
    CMD_DIGIT6   = 5'h0d,
    CMD_MUTE_ONE = 5'h0e,
    CMD_FASTFWD  = 5'h10,
    CMD_DIGIT1   = 5'h11,
    CMD_STEPREV  = 5'h12,
    CMD_DIGIT9   = 5'h13,
    CMD_PLAY     = 5'h14,
    CMD_DIGIT5   = 5'h15,
    CMD_MUTE_TWO = 5'h16,
    CMD_SLOWFWD  = 5'h18,
    CMD_DIGIT3   = 5'h19,
    CMD_SEEK     = 5'h1a,
    CMD_SCANREV  = 5'h1c,
    CMD_DIGIT7   = 5'h1d,
    CMD_EJECT    = 5'h1e
  } cmd_code_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_NONE    = 4'd0,
    REQ_SLOWREV = 4'd1,
    REQ_SLOWFWD = 4'd2,
    REQ_FASTREV = 4'd3,
    REQ_FASTFWD = 4'd4,
    REQ_STEPREV = 4'd5,
    REQ_STEPFWD = 4'd6,
    REQ_SCANFWD = 4'd7,
    REQ_SCANREV = 4'd8,
    REQ_RESCAN  = 4'd9,
    REQ_PAUSE   = 4'd10,
    REQ_PLAY    = 4'd11,
    REQ_LOAD    = 4'd12,
    REQ_SPINUP  = 4'd13,
    REQ_EJECT   = 4'd14,
    REQ_SEEK    = 4'd15
  } req_t;

  // Player state seen by the decoder.
  typedef struct packed {
    logic [NUM_W-1:0] entered_number;
    logic             seek_armed;
    logic             mute_one;
    logic             mute_two;
  } player_regs_t;

  // What a confirmed code does: the request and the player registers after it.
  typedef struct packed {
    req_t             request;
    logic [NUM_W-1:0] request_value;
    player_regs_t     regs;
  } cmd_action_t;

endpackage

FILE: hw/rtl/picr_cmd_decode.sv
// Command decoder of the pulse interval command receiver: maps a confirmed code
// to a request and the updated number, seek and mute registers.
// Depends on picr_pkg.
`timescale 1ns / 1ps

module picr_cmd_decode (
  input  logic [picr_pkg::CODE_W-1:0] code,
  input  picr_pkg::pstate_t           pstate,
  input  picr_pkg::player_regs_t      regs_cur,
  output picr_pkg::cmd_action_t       action
);

  logic                           is_digit;
  logic [3:0]                     digit;
  logic [picr_pkg::NUM_W+3:0]     num_times_ten;
  logic [picr_pkg::NUM_W+3:0]     num_sum;
  logic [picr_pkg::NUM_W-1:0]     num_digit;

  always_comb begin
    is_digit = 1'b1;
    digit    = 4'd0;
    case (picr_pkg::cmd_code_t'(code))
      picr_pkg::CMD_DIGIT0: digit = 4'd0;
      picr_pkg::CMD_DIGIT1: digit = 4'd1;
      picr_pkg::CMD_DIGIT2: digit = 4'd2;
      picr_pkg::CMD_DIGIT3: digit = 4'd3;
      picr_pkg::CMD_DIGIT4: digit = 4'd4;
      picr_pkg::CMD_DIGIT5: digit = 4'd5;
      picr_pkg::CMD_DIGIT6: digit = 4'd6;
      picr_pkg::CMD_DIGIT7: digit = 4'd7;
      picr_pkg::CMD_DIGIT8: digit = 4'd8;
      picr_pkg::CMD_DIGIT9: digit = 4'd9;
      default:              is_digit = 1'b0;
    endcase
  end

  // Times ten as two shifts and an add.
  assign num_times_ten = {1'b0, regs_cur.entered_number, 3'b000}
                       + {3'b000, regs_cur.entered_number, 1'b0};
  assign num_sum       = num_times_ten + {(picr_pkg::NUM_W)'(0), digit};
  assign num_digit     = (num_sum > {4'd0, picr_pkg::NUM_MAX}) ? picr_pkg::NUM_MAX
                                                                : num_sum[picr_pkg::NUM_W-1:0];

  always_comb begin
    action.request       = picr_pkg::REQ_NONE;
    action.request_value = '0;
    action.regs          = regs_cur;
    if (is_digit) begin
      action.regs.entered_number = num_digit;
    end else begin
      case (picr_pkg::cmd_code_t'(code))
        picr_pkg::CMD_SLOWREV: begin
          action.request       = picr_pkg::REQ_SLOWREV;
          action.request_value = picr_pkg::SPEED_SLOW;
        end
        picr_pkg::CMD_SLOWFWD: begin
          action.request       = picr_pkg::REQ_SLOWFWD;
          action.request_value = picr_pkg::SPEED_SLOW;
        end
        picr_pkg::CMD_FASTREV: begin
          action.request       = picr_pkg::REQ_FASTREV;
          action.request_value = picr_pkg::SPEED_FAST;
        end
        picr_pkg::CMD_FASTFWD: begin
          action.request       = picr_pkg::REQ_FASTFWD;
          action.request_value = picr_pkg::SPEED_FAST;
        end
        picr_pkg::CMD_STEPFWD: action.request = picr_pkg::REQ_STEPFWD;
        picr_pkg::CMD_STEPREV: action.request = picr_pkg::REQ_STEPREV;
        picr_pkg::CMD_PAUSE:   action.request = picr_pkg::REQ_PAUSE;
        picr_pkg::CMD_EJECT:   action.request = picr_pkg::REQ_EJECT;
        picr_pkg::CMD_SCANFWD: begin
          action.request = (pstate == picr_pkg::PS_SCANNING) ? picr_pkg::REQ_RESCAN
                                                             : picr_pkg::REQ_SCANFWD;
        end
        picr_pkg::CMD_SCANREV: begin
          action.request = (pstate == picr_pkg::PS_SCANNING) ? picr_pkg::REQ_RESCAN
                                                             : picr_pkg::REQ_SCANREV;
        end
        picr_pkg::CMD_PLAY: begin
          case (pstate)
            picr_pkg::PS_EJECTED: action.request = picr_pkg::REQ_LOAD;
            picr_pkg::PS_PARKED:  action.request = picr_pkg::REQ_SPINUP;
            default:              action.request = picr_pkg::REQ_PLAY;
          endcase
        end
        picr_pkg::CMD_MUTE_ONE: action.regs.mute_one = ~regs_cur.mute_one;
        picr_pkg::CMD_MUTE_TWO: action.regs.mute_two = ~regs_cur.mute_two;
        picr_pkg::CMD_SEEK: begin
          // The first seek clears the number and arms; the second fires it.
          if (regs_cur.seek_armed) begin
            action.request       = picr_pkg::REQ_SEEK;
            action.request_value = regs_cur.entered_number;
          end else begin
            action.regs.entered_number = '0;
          end
          action.regs.seek_armed = ~regs_cur.seek_armed;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pulse_interval_command_receiver_top.sv
// Top level of the pulse interval command receiver: input register, frame bit
// recovery, code confirmation and result register. Depends on picr_pkg and
// picr_cmd_decode.
`timescale 1ns / 1ps

// How to use this block:
// Each request on the input stream reports one level change of the remote
// control line with its free-running microsecond time stamp. Asserted edges
// shift one bit into the frame register (a one when the gap since the previous
// asserted edge reaches long_gap_us); released edges change nothing. A code is
// acted on only when the same code is framed twice in a row.
// Every input request produces exactly one result request, carrying the
// confirmed code, the transport request with its value and the current mutes.
// The result is registered: an accepted request waits in the input register and its
// result is captured in the result register. Throughput is one request per cycle
// unless the output stalls: all the work for an edge is a single pass of short logic
// between the two registers, so a new edge can follow in the very next cycle.
// When the output is stalled, the result register holds its request and the
// input register still takes one more request before in_tready falls.
// Reset (synchronous, rst_n low) empties both registers, clears the frame,
// stamps, pending code, entered number, seek arm and mutes, and loads the
// default frame timeout and long gap. Configuration writes through cfg_* take
// effect at once and are meant only while no request is in flight.
module pulse_interval_command_receiver_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata from bit 0: edge_time_us[31:0], line_level[32], player_state[34:33], zero fill.
  input  logic [picr_pkg::IN_DATA_W-1:0]      in_tdata,
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata from bit 0: command_done[0], command_code[5:1], request[9:6],
  // request_value[36:10], audio_one_muted[37], audio_two_muted[38], zero fill.
  output logic [picr_pkg::OUT_DATA_W-1:0]     out_tdata,
  // Configuration write port.
  input  logic                                cfg_wen,
  input  logic [picr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [picr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [picr_pkg::TOUT_W-1:0]   frame_timeout_r;
  logic [picr_pkg::GAP_W-1:0]    long_gap_r;

  // Input register.
  logic                          in_valid_r;
  logic [picr_pkg::TIME_W-1:0]   edge_time_r;
  logic                          line_level_r;
  picr_pkg::pstate_t             pstate_r;

  // Receiver state.
  logic [picr_pkg::SHIFT_W-1:0]  bit_shift_r, bit_shift_nxt;
  logic [picr_pkg::TIME_W-1:0]   first_stamp_r, first_stamp_nxt;
  logic [picr_pkg::TIME_W-1:0]   prev_stamp_r, prev_stamp_nxt;
  logic [picr_pkg::CODE_W-1:0]   pending_code_r, pending_code_nxt;
  picr_pkg::player_regs_t        regs_r, regs_nxt;

  // Result register.
  logic                          out_valid_r;
  logic [picr_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                          advance;
  logic                          process;
  logic [picr_pkg::TIME_W-1:0]   since_first;
  logic [picr_pkg::TIME_W-1:0]   gap;
  logic                          restart;
  logic                          long_bit;
  logic [picr_pkg::SHIFT_W-1:0]  shift_base;
  logic [picr_pkg::SHIFT_W-1:0]  shifted;
  logic                          framed;
  logic [picr_pkg::CODE_W-1:0]   framed_code;
  logic                          confirmed;
  picr_pkg::cmd_action_t         action;
  logic                          res_done;
  logic [picr_pkg::CODE_W-1:0]   res_code;
  picr_pkg::req_t                res_req;
  logic [picr_pkg::NUM_W-1:0]    res_value;

  // The result register empties when taken or is empty already.
  assign advance   = !out_valid_r || out_tready;
  assign process   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_timeout_r <= picr_pkg::FRAME_TIMEOUT_RST;
      long_gap_r      <= picr_pkg::LONG_GAP_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        picr_pkg::CFG_FRAME_TIMEOUT: frame_timeout_r <= cfg_wdata[picr_pkg::TOUT_W-1:0];
        picr_pkg::CFG_LONG_GAP:      long_gap_r      <= cfg_wdata[picr_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      edge_time_r  <= in_tdata[31:0];
      line_level_r <= in_tdata[32];
      pstate_r     <= picr_pkg::pstate_t'(in_tdata[34:33]);
    end
  end

  // Frame bit recovery. Time differences wrap modulo two to the 32nd.
  assign since_first = edge_time_r - first_stamp_r;
  assign gap         = edge_time_r - prev_stamp_r;
  assign restart     = since_first > {12'd0, frame_timeout_r};
  assign long_bit    = gap >= {15'd0, long_gap_r};
  assign shift_base  = restart ? picr_pkg::RESTART_PATTERN : bit_shift_r;
  assign shifted     = {shift_base[picr_pkg::SHIFT_W-2:0], long_bit};
  // Frame is 0,0,1, five code bits, 0,0 with the newest bit lowest.
  assign framed      = (shifted & picr_pkg::FRAME_MASK) == picr_pkg::FRAME_MATCH;
  assign framed_code = shifted[6:2];
  assign confirmed   = framed && (framed_code == pending_code_r);

  picr_cmd_decode u_cmd_decode (
    .code     (framed_code),
    .pstate   (pstate_r),
    .regs_cur (regs_r),
    .action   (action)
  );

  always_comb begin
    bit_shift_nxt    = bit_shift_r;
    first_stamp_nxt  = first_stamp_r;
    prev_stamp_nxt   = prev_stamp_r;
    pending_code_nxt = pending_code_r;
    regs_nxt         = regs_r;
    res_done         = 1'b0;
    res_code         = '0;
    res_req          = picr_pkg::REQ_NONE;
    res_value        = '0;
    if (line_level_r) begin
      if (restart) begin
        first_stamp_nxt = edge_time_r;
      end
      prev_stamp_nxt = edge_time_r;
      bit_shift_nxt  = shifted;
      if (confirmed) begin
        res_done         = 1'b1;
        res_code         = framed_code;
        res_req          = action.request;
        res_value        = action.request_value;
        regs_nxt         = action.regs;
        pending_code_nxt = '0;
      end else if (framed) begin
        pending_code_nxt = framed_code;
      end
    end
    out_data_nxt = {1'b0, regs_nxt.mute_two, regs_nxt.mute_one, res_value,
                    res_req, res_code, res_done};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_shift_r    <= '0;
      first_stamp_r  <= '0;
      prev_stamp_r   <= '0;
      pending_code_r <= '0;
      regs_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (process) begin
        bit_shift_r    <= bit_shift_nxt;
        first_stamp_r  <= first_stamp_nxt;
        prev_stamp_r   <= prev_stamp_nxt;
        pending_code_r <= pending_code_nxt;
        regs_r         <= regs_nxt;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hw/rtl/picr_checker.sv
// Port checker for the pulse interval command receiver, bound to the top level.
// Depends on picr_pkg and pulse_interval_command_receiver_top.
`timescale 1ns / 1ps

module picr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [picr_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result keeps its request and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Without a confirmed code there is no code, request or value.
  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[36:1] == '0)
    else $error("unconfirmed result carries a command");

  // A request value only comes with a request.
  a_value_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9:6] == picr_pkg::REQ_NONE |-> out_tdata[36:10] == '0)
    else $error("request value without request");

  // The entered number saturates at eight decimal digits.
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[36:10] <= picr_pkg::NUM_MAX)
    else $error("request value out of range");

endmodule

bind pulse_interval_command_receiver_top picr_checker u_picr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: verif/picr_result_checker.sv
// Result checker for the pulse interval command receiver. It follows the input, result and
// configuration ports, predicts every result and compares it field by field.
// Depends on picr_pkg.
`timescale 1ns / 1ps

module picr_result_checker
  import picr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    results_in_flight
);

  typedef struct {
    logic              done;
    logic [CODE_W-1:0] code;
    req_t              req;
    logic [NUM_W-1:0]  value;
    logic              mute_one;
    logic              mute_two;
  } edge_result_t;

  localparam int REPORT_LIMIT = 100;

  logic [TOUT_W-1:0]  timeout_us;
  logic [GAP_W-1:0]   long_gap_us;
  logic [SHIFT_W-1:0] frame_bits;
  logic [TIME_W-1:0]  first_stamp;
  logic [TIME_W-1:0]  last_stamp;
  logic [CODE_W-1:0]  held_code;
  logic [NUM_W-1:0]   typed_number;
  logic               seek_armed;
  logic               mute_one;
  logic               mute_two;
  edge_result_t       expected_results[$];

  initial begin
    mismatches = 0;
    results_in_flight = 0;
  end

  function automatic int digit_value(input logic [CODE_W-1:0] c);
    case (c)
      CMD_DIGIT0: return 0;
      CMD_DIGIT1: return 1;
      CMD_DIGIT2: return 2;
      CMD_DIGIT3: return 3;
      CMD_DIGIT4: return 4;
      CMD_DIGIT5: return 5;
      CMD_DIGIT6: return 6;
      CMD_DIGIT7: return 7;
      CMD_DIGIT8: return 8;
      CMD_DIGIT9: return 9;
      default:    return -1;
    endcase
  endfunction

  // Carries out a confirmed code on the player registers.
  function automatic void carry_out(input logic [CODE_W-1:0] c, input pstate_t ps,
                                    output req_t req, output logic [NUM_W-1:0] value);
    int d;
    logic [63:0] sum;
    d = digit_value(c);
    req = REQ_NONE;
    value = '0;
    if (d >= 0) begin
      sum = 64'(typed_number) * 64'd10 + 64'(d);
      typed_number = (sum > 64'(NUM_MAX)) ? NUM_MAX : sum[NUM_W-1:0];
    end else begin
      case (c)
        CMD_SLOWREV: begin
          req = REQ_SLOWREV;
          value = SPEED_SLOW;
        end
        CMD_SLOWFWD: begin
          req = REQ_SLOWFWD;
          value = SPEED_SLOW;
        end
        CMD_FASTREV: begin
          req = REQ_FASTREV;
          value = SPEED_FAST;
        end
        CMD_FASTFWD: begin
          req = REQ_FASTFWD;
          value = SPEED_FAST;
        end
        CMD_STEPFWD:  req = REQ_STEPFWD;
        CMD_STEPREV:  req = REQ_STEPREV;
        CMD_PAUSE:    req = REQ_PAUSE;
        CMD_EJECT:    req = REQ_EJECT;
        CMD_SCANFWD:  req = (ps == PS_SCANNING) ? REQ_RESCAN : REQ_SCANFWD;
        CMD_SCANREV:  req = (ps == PS_SCANNING) ? REQ_RESCAN : REQ_SCANREV;
        CMD_PLAY:     req = (ps == PS_EJECTED) ? REQ_LOAD :
                            (ps == PS_PARKED) ? REQ_SPINUP : REQ_PLAY;
        CMD_MUTE_ONE: mute_one = ~mute_one;
        CMD_MUTE_TWO: mute_two = ~mute_two;
        CMD_SEEK: begin
          if (seek_armed) begin
            req = REQ_SEEK;
            value = typed_number;
          end else begin
            typed_number = '0;
          end
          seek_armed = ~seek_armed;
        end
        default: ;
      endcase
    end
  endfunction

  // Advances the frame state by one line edge and returns the result it yields.
  function automatic edge_result_t decode_edge(input logic [TIME_W-1:0] stamp,
                                               input logic level, input pstate_t ps);
    edge_result_t r;
    logic [TIME_W-1:0] since_first;
    logic [TIME_W-1:0] gap;
    logic [CODE_W-1:0] c;
    r.done = 1'b0;
    r.code = '0;
    r.req = REQ_NONE;
    r.value = '0;
    if (level) begin
      since_first = stamp - first_stamp;
      if (since_first > TIME_W'(timeout_us)) begin
        first_stamp = stamp;
        frame_bits = RESTART_PATTERN;
      end
      gap = stamp - last_stamp;
      last_stamp = stamp;
      frame_bits = {frame_bits[SHIFT_W-2:0], gap >= TIME_W'(long_gap_us)};
      if ((frame_bits & FRAME_MASK) == FRAME_MATCH) begin
        c = frame_bits[6:2];
        if (c == held_code) begin
          r.done = 1'b1;
          r.code = c;
          carry_out(c, ps, r.req, r.value);
          held_code = '0;
        end else begin
          held_code = c;
        end
      end
    end
    r.mute_one = mute_one;
    r.mute_two = mute_two;
    return r;
  endfunction

  function automatic bit field_differs(input string name, input longint unsigned want,
                                       input longint unsigned got);
    if (want == got) return 1'b0;
    if (mismatches < REPORT_LIMIT)
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    edge_result_t want;
    bit wrong;
    if (!rst_n) begin
      timeout_us = FRAME_TIMEOUT_RST;
      long_gap_us = LONG_GAP_RST;
      frame_bits = '0;
      first_stamp = '0;
      last_stamp = '0;
      held_code = '0;
      typed_number = '0;
      seek_armed = 1'b0;
      mute_one = 1'b0;
      mute_two = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_FRAME_TIMEOUT: timeout_us = cfg_wdata[TOUT_W-1:0];
          CFG_LONG_GAP:      long_gap_us = cfg_wdata[GAP_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result expected none, got %0h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          wrong = 1'b0;
          wrong |= field_differs("command_done", want.done, out_tdata[0]);
          wrong |= field_differs("command_code", want.code, out_tdata[5:1]);
          wrong |= field_differs("request", want.req, out_tdata[9:6]);
          wrong |= field_differs("request_value", want.value, out_tdata[36:10]);
          wrong |= field_differs("audio_one_muted", want.mute_one, out_tdata[37]);
          wrong |= field_differs("audio_two_muted", want.mute_two, out_tdata[38]);
          if (wrong) mismatches++;
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(decode_edge(in_tdata[31:0], in_tdata[32],
                                               pstate_t'(in_tdata[34:33])));
    end
    results_in_flight = expected_results.size();
  end

endmodule

FILE: verif/testbench.sv
// Top of the pulse interval command receiver testbench: clock, reset, stimulus, receiver
// back-pressure and the final verdict. Depends on picr_pkg, picr_result_checker and
// pulse_interval_command_receiver_top.
`timescale 1ns / 1ps

module testbench;
  import picr_pkg::*;

  localparam int LONG_HOLD_CYCLES = 300;
  // Codes with no named command: zero confirms on its own right after reset, and
  // an unassigned code is confirmed without any effect.
  localparam logic [CODE_W-1:0] CODE_NONE   = 5'h00;
  localparam logic [CODE_W-1:0] CODE_UNUSED = 5'h06;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    mismatches;
  int                    results_in_flight;

  // Stimulus-side view of the line: the running microsecond clock, the stamp of
  // the edge that opened the current frame and the register values in force.
  logic [TIME_W-1:0] now_us = '0;
  logic [TIME_W-1:0] frame_start_us = '0;
  int unsigned       timeout_us = FRAME_TIMEOUT_RST;
  int unsigned       long_gap_us = LONG_GAP_RST;
  int unsigned       asserted_sent = 0;
  int unsigned       sender_idle_pct = 0;
  int unsigned       receiver_stall_pct = 0;
  int                long_holds_asked = 0;
  int                long_holds_done = 0;
  int                hold_left = 0;
  cmd_code_t         digit_codes[10] = '{CMD_DIGIT0, CMD_DIGIT1, CMD_DIGIT2, CMD_DIGIT3,
                                         CMD_DIGIT4, CMD_DIGIT5, CMD_DIGIT6, CMD_DIGIT7,
                                         CMD_DIGIT8, CMD_DIGIT9};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pulse_interval_command_receiver_top DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_wen, .cfg_index, .cfg_wdata
  );

  picr_result_checker result_check (.*);

  // Receiver side. A long hold asked for by the stimulus keeps out_tready low until the
  // hold runs out, so the result and input registers both fill and the block has to
  // push back on its input. Otherwise it stalls at the current rate.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (long_holds_done != long_holds_asked) begin
      long_holds_done++;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  function automatic pstate_t any_state();
    return pstate_t'($urandom_range(0, 3));
  endfunction

  // Offers one line edge and waits until the block takes the request. The sender
  // may idle first; tvalid stays high from one request to the next when it doesn't.
  task automatic send_edge(input logic [TIME_W-1:0] stamp, input logic level,
                           input pstate_t ps);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'({ps, level, stamp});
    do @(posedge clk); while (!in_tready);
    if (level) asserted_sent++;
  endtask

  // One well-formed frame. The opening edge comes after the frame timeout, so the
  // receiver restarts the frame; ten more asserted edges then carry 0,0,1, the five
  // code bits and 0,0 as short and long gaps. Long gaps are kept short enough that
  // the whole frame fits in the timeout whenever the registers allow it.
  // Released edges are scattered in between with random content.
  task automatic send_frame(input logic [CODE_W-1:0] code, input pstate_t ps);
    logic [9:0] pattern;
    int unsigned slack;
    int unsigned gap;
    pattern = {3'b001, code, 2'b00};
    slack = (timeout_us / 10 > long_gap_us) ? timeout_us / 10 - long_gap_us : 0;
    now_us += TIME_W'(timeout_us + 1 + $urandom_range(0, 2000));
    frame_start_us = now_us;
    send_edge(now_us, 1'b1, ps);
    for (int i = 9; i >= 0; i--) begin
      if (pattern[i])
        gap = long_gap_us + $urandom_range(0, slack);
      else
        gap = (long_gap_us == 0) ? 0 : $urandom_range(0, long_gap_us - 1);
      now_us += TIME_W'(gap);
      if ($urandom_range(0, 99) < 15) send_edge($urandom, 1'b0, any_state());
      send_edge(now_us, 1'b1, ps);
    end
  endtask

  // A code only counts when it is framed twice in a row.
  task automatic send_command(input logic [CODE_W-1:0] code, input pstate_t ps);
    send_frame(code, ps);
    send_frame(code, ps);
  endtask

  // Loose edges: random levels and gaps, with gaps of exactly the long-gap
  // threshold and one below it, and now and then a jump to a random time.
  task automatic send_noise(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        now_us = $urandom;
      else if (pick == 1)
        now_us += TIME_W'(long_gap_us);
      else if (pick == 2)
        now_us += TIME_W'((long_gap_us == 0) ? 0 : long_gap_us - 1);
      else
        now_us += TIME_W'($urandom_range(0, 2 * long_gap_us + 1));
      send_edge(now_us, 1'($urandom_range(0, 1)), any_state());
    end
  endtask

  // Lowers tvalid and waits until every expected result has come back. Every
  // request yields a result, so nothing is in flight after that.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (results_in_flight == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (idx == CFG_FRAME_TIMEOUT)
      timeout_us = value;
    else
      long_gap_us = value;
  endtask

  // Mostly confirmed commands with random codes and player states, plus seek
  // sequences with a typed number in between (now and then long enough to
  // saturate), lone frames that confirm only on a pending match, and loose edges.
  task automatic run_random(input int unsigned count);
    int unsigned target;
    int unsigned roll;
    int unsigned digits;
    target = asserted_sent + count;
    while (asserted_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        send_command(CMD_SEEK, any_state());
        digits = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 3);
        repeat (digits) send_command(digit_codes[$urandom_range(0, 9)], any_state());
        send_command(CMD_SEEK, any_state());
      end else if (roll < 70) begin
        send_command(CODE_W'($urandom_range(0, 31)), any_state());
      end else if (roll < 80) begin
        send_frame(CODE_W'($urandom_range(0, 31)), any_state());
      end else begin
        send_noise($urandom_range(1, 12));
      end
    end
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic run_phase(input int unsigned tout, input int unsigned gap,
                           input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit long_hold, input int unsigned count);
    drain_results();
    write_reg(CFG_FRAME_TIMEOUT, tout);
    write_reg(CFG_LONG_GAP, gap);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    if (long_hold) long_holds_asked++;
    run_random(count);
  endtask

  initial begin
    int unsigned tout_pick;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset register values, with no idling. Released edges
    // at both ends of the time range, then an asserted edge at the top of the
    // range so that the following frames wrap the microsecond clock.
    send_edge('1, 1'b0, PS_SCANNING);
    send_edge('0, 1'b0, PS_OTHER);
    send_edge('1, 1'b1, PS_SCANNING);
    now_us = '1;
    // Code zero matches the cleared pending code, so each of these frames
    // confirms with no request.
    send_command(CODE_NONE, PS_OTHER);
    // Arm the seek, type every digit (ten of them, past the saturation point)
    // and fire the seek with the saturated number.
    send_command(CMD_SEEK, PS_OTHER);
    for (int d = 9; d >= 0; d--) send_command(digit_codes[d], PS_OTHER);
    send_command(CMD_SEEK, PS_PARKED);
    // A slow and a fast speed request, then every command whose request depends on
    // the player state. The plain transport commands come from the random part.
    send_command(CMD_SLOWREV, PS_OTHER);
    send_command(CMD_FASTFWD, PS_EJECTED);
    send_command(CMD_SCANFWD, PS_OTHER);
    send_command(CMD_SCANFWD, PS_SCANNING);
    send_command(CMD_SCANREV, PS_OTHER);
    send_command(CMD_SCANREV, PS_SCANNING);
    send_command(CMD_PLAY, PS_OTHER);
    send_command(CMD_PLAY, PS_EJECTED);
    send_command(CMD_PLAY, PS_PARKED);
    send_command(CMD_MUTE_ONE, PS_OTHER);
    send_command(CMD_MUTE_TWO, PS_SCANNING);
    send_command(CODE_UNUSED, PS_OTHER);
    // Two different codes in a row confirm nothing; the next repeat does.
    send_frame(CMD_PAUSE, PS_OTHER);
    send_command(CMD_MUTE_ONE, PS_OTHER);
    // An edge exactly one timeout after the frame start keeps the frame; one
    // microsecond later it restarts.
    send_edge(frame_start_us + TIME_W'(timeout_us), 1'b1, PS_OTHER);
    now_us = frame_start_us + TIME_W'(timeout_us + 1);
    send_edge(now_us, 1'b1, PS_OTHER);

    // Random phases. The first opens with a long receiver hold while the sender
    // keeps offering. The others set the registers large, to zero, to random values,
    // to a long gap beyond the timeout that breaks every frame, and to moderate values.
    run_phase(FRAME_TIMEOUT_RST, LONG_GAP_RST, 0, 0, 1'b1, 30);
    run_phase(1000000, 100000, 68, 0, 1'b0, 30);
    run_phase(0, 0, 0, 68, 1'b0, 25);
    tout_pick = $urandom_range(20000, 1000000);
    run_phase(tout_pick, $urandom_range(50, tout_pick / 12), 36, 36, 1'b0, 30);
    run_phase(1000, 100000, 36, 36, 1'b0, 15);
    run_phase(40000, 2000, 0, 0, 1'b0, 30);

    // Wait out the pipeline so that a stray extra result would still be caught.
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Far beyond the slowest correct run; reaching it means the block hung.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
